### hdl/crls_pkg.sv
package crls_pkg;

  localparam int unsigned LayerCount = 64;
  localparam int unsigned LayerW = (LayerCount > 1) ? $clog2(LayerCount) : 1;
  localparam int unsigned SumW = 50;
  localparam int unsigned CountW = 20;
  localparam int unsigned PeakW = 15;
  localparam int unsigned CoordW = 20;
  localparam int unsigned SelW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [PeakW-1:0] PeakMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegAxisX   = 2'd0,
    RegAxisY   = 2'd1,
    RegRadius  = 2'd2,
    RegLowest  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OpPoint = 1'b0,
    OpRead  = 1'b1
  } op_e;

  // request classified by the front part
  typedef struct packed {
    op_e               op;
    logic [41:0]       dist_sq;
    logic              in_win;
    logic [LayerW-1:0] entry;
    logic [SelW-1:0]   sel;
  } req_t;

  // result handed to the output register
  typedef struct packed {
    logic signed [15:0] deviation;
    logic [SelW-1:0]    layer_index;
    logic               in_window;
    logic [CountW-1:0]  point_count;
    logic [PeakW-1:0]   layer_rmse;
    logic [PeakW-1:0]   layer_max;
  } res_t;

endpackage

### hdl/crls_sqrt.sv
module crls_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] rad_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [25:0] root_o
);
  import crls_pkg::*;

  logic [51:0] rem_q, rem_d;
  logic [51:0] root_q, root_d;
  logic [51:0] bit_q, bit_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [52:0] trial;

  // one result bit a cycle: the test bit moves down two places
  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    if (start_i) begin
      rem_d  = {2'b00, rad_i};
      root_d = '0;
      bit_d  = 52'd1 << 50;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d  = rem_q - trial[51:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // round to nearest
  assign root_o = (root_q < rem_q) ? 26'(root_q) + 26'd1 : 26'(root_q);
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

### hdl/crls_front.sv
module crls_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               take_i,
  input  logic                               opcode_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_z_i,
  input  logic [crls_pkg::SelW-1:0]          layer_select_i,
  input  logic signed [crls_pkg::CoordW-1:0] axis_x_i,
  input  logic signed [crls_pkg::CoordW-1:0] axis_y_i,
  input  logic signed [9:0]                  lowest_i,
  input  logic                               deq_i,
  output logic                               full_o,
  output logic                               avail_o,
  output crls_pkg::req_t                     req_o
);
  import crls_pkg::*;

  // stage 1: differences and layer window
  logic        s1_q;
  op_e         op1_q;
  logic signed [20:0] dx_q, dy_q;
  logic        win1_q;
  logic [LayerW-1:0] ent1_q;
  logic [SelW-1:0]   sel1_q;
  logic signed [10:0] layer;
  logic signed [11:0] entry;
  // stage 2: squares
  logic        s2_q;
  op_e         op2_q;
  logic [41:0] sqx_q, sqy_q;
  logic        win2_q;
  logic [LayerW-1:0] ent2_q;
  logic [SelW-1:0]   sel2_q;
  // two-entry queue
  req_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  req_t        wr;

  assign layer = 11'(signed'({1'b0, pos_z_i[19:10] ^ 10'h200})) - 11'sd512;
  assign entry = 12'(layer) - 12'(lowest_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= take_i;
      s2_q <= s1_q;
    end
  end

  // compute differences and squares
  always_ff @(posedge clk_i) begin
    op1_q  <= op_e'(opcode_i);
    dx_q   <= 21'(pos_x_i) - 21'(axis_x_i);
    dy_q   <= 21'(pos_y_i) - 21'(axis_y_i);
    win1_q <= (entry >= 0) && (entry < 12'(LayerCount));
    ent1_q <= entry[LayerW-1:0];
    sel1_q <= layer_select_i;
    op2_q  <= op1_q;
    sqx_q  <= 42'(dx_q) * 42'(dx_q);
    sqy_q  <= 42'(dy_q) * 42'(dy_q);
    win2_q <= win1_q;
    ent2_q <= ent1_q;
    sel2_q <= sel1_q;
  end

  assign wr = '{op: op2_q, dist_sq: sqx_q + sqy_q, in_win: win2_q,
                entry: ent2_q, sel: sel2_q};

  // push finished request, pop on back request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (s2_q) wp_q <= ~wp_q;
      if (deq_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(s2_q) - 2'(deq_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) fifo_q[wp_q] <= wr;
  end

  // hold new requests while anything may overflow the queue
  assign full_o  = (cnt_q != 2'd0) || s1_q || s2_q;
  assign avail_o = (cnt_q != 2'd0);
  assign req_o   = fifo_q[rp_q];

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> cnt_q != 2'd0) else $error("queue underflow");
  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |=> !take_i) else $error("two requests in flight");
`endif

endmodule

### hdl/crls_back.sv
module crls_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  crls_pkg::req_t          req_i,
  input  logic [18:0]             radius_i,
  input  logic                    out_free_i,
  output logic                    deq_o,
  output logic                    res_vld_o,
  output crls_pkg::res_t          res_o
);
  import crls_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRoot  = 7'b0000010,
    StRead  = 7'b0000100,
    StWrite = 7'b0001000,
    StDiv   = 7'b0010000,
    StRms   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [LayerCount-1:0] clr_q;
  logic [SumW-1:0]   sum_mem  [LayerCount];
  logic [CountW-1:0] cnt_mem  [LayerCount];
  logic [PeakW-1:0]  peak_mem [LayerCount];
  logic [SumW-1:0]   sum_rd_q;
  logic [CountW-1:0] cnt_rd_q;
  logic [PeakW-1:0]  peak_rd_q;
  req_t              req_q;
  logic signed [15:0] dev_q;
  logic [PeakW-1:0]  mag_q;
  logic [SumW-1:0]   quo_q, rem_q;
  logic [CountW-1:0] cnt_q;
  logic [PeakW-1:0]  peak_q;
  logic [5:0]        div_i_q;
  logic              sq_start, sq_busy, sq_done;
  logic [49:0]       sq_rad;
  logic [25:0]       sq_root;
  logic              rootdone_q;
  logic signed [27:0] dev_full;
  logic signed [15:0] dev_sat;
  logic [PeakW-1:0]   mag;
  logic              upd;
  logic [SumW-1:0]   sum_new;
  logic [CountW-1:0] cnt_new;
  logic [PeakW-1:0]  peak_new;
  logic [SumW:0]     rem_sh;
  logic [SumW-1:0]   quo_last;
  logic              sel_ok;
  res_t              res_q;
  logic              res_vld_q;

  crls_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i(sq_start), .rad_i(sq_rad),
    .busy_o(sq_busy), .done_o(sq_done), .root_o(sq_root)
  );

  assign dev_full = 28'(signed'({2'b0, sq_root})) - 28'(signed'({1'b0, radius_i}));
  assign dev_sat  = (dev_full > 28'sd32767) ? 16'sd32767 :
                    (dev_full < -28'sd32768) ? -16'sd32768 : dev_full[15:0];
  assign mag      = dev_sat[15] ? ((dev_sat == -16'sd32768) ? PeakMax
                                   : PeakW'(-dev_sat)) : dev_sat[14:0];

  // update stats of the hit entry
  assign upd      = (cnt_rd_q != CountMax);
  assign cnt_new  = upd ? cnt_rd_q + CountW'(1) : cnt_rd_q;
  assign sum_new  = upd ? sum_rd_q + SumW'({15'd0, mag_q} * {15'd0, mag_q}) : sum_rd_q;
  assign peak_new = (mag_q > peak_rd_q) ? mag_q : peak_rd_q;

  assign rem_sh   = {rem_q, quo_q[SumW-1]};
  assign quo_last = {quo_q[SumW-2:0], (rem_sh >= (SumW+1)'(cnt_q))};

  // read select within the table
  assign sel_ok = (32'(req_q.sel) < LayerCount);

  assign deq_o = (state_q == StIdle) && avail_i && !res_vld_q;
  assign sq_start = (deq_o && req_i.op == OpPoint) ||
                    (state_q == StDiv && div_i_q == 6'd0);
  assign sq_rad = (state_q == StDiv) ? quo_last : 50'(req_i.dist_sq);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (deq_o) state_d = (req_i.op == OpPoint) ? StRoot : StRead;
      StRoot:  if (rootdone_q) state_d = req_q.in_win ? StRead : StOut;
      StRead:  state_d = (req_q.op == OpPoint) ? StWrite :
                         sel_ok ? StDiv : StOut;
      StWrite: state_d = StDiv;
      StDiv:   if (div_i_q == 6'd0) state_d = StRms;
      StRms:   if (rootdone_q) state_d = StOut;
      StOut:   if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      clr_q      <= '0;
      res_vld_q  <= 1'b0;
      rootdone_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rootdone_q <= sq_done;
      if (state_q == StWrite) clr_q[req_q.entry] <= 1'b1;
      if (state_q == StOut && out_free_i) res_vld_q <= 1'b1;
      else if (out_free_i) res_vld_q <= 1'b0;
    end
  end

  // memories: registered reads, one write port
  always_ff @(posedge clk_i) begin
    if (state_q == StRoot || (state_q == StIdle && deq_o)) begin
      sum_rd_q  <= '0;
      cnt_rd_q  <= '0;
      peak_rd_q <= '0;
    end
    if (state_q == StRead) begin
      sum_rd_q  <= clr_q[req_q.entry] ? sum_mem[req_q.entry] : '0;
      cnt_rd_q  <= clr_q[req_q.entry] ? cnt_mem[req_q.entry] : '0;
      peak_rd_q <= clr_q[req_q.entry] ? peak_mem[req_q.entry] : '0;
    end
    if (state_q == StWrite) begin
      sum_mem[req_q.entry]  <= sum_new;
      cnt_mem[req_q.entry]  <= cnt_new;
      peak_mem[req_q.entry] <= peak_new;
    end
  end

  // datapath: capture request, deviation, stats, then long division
  always_ff @(posedge clk_i) begin
    if (deq_o) begin
      req_q <= req_i;
      dev_q <= '0;
      if (req_i.op == OpRead) req_q.entry <= req_i.sel[LayerW-1:0];
    end
    if (state_q == StRoot && rootdone_q) begin
      dev_q <= dev_sat;
      mag_q <= mag;
    end
    if (state_q == StRead && req_q.op == OpRead) begin
      // read path goes straight to division
      cnt_q  <= clr_q[req_q.entry] ? cnt_mem[req_q.entry] : '0;
      peak_q <= clr_q[req_q.entry] ? peak_mem[req_q.entry] : '0;
      quo_q  <= clr_q[req_q.entry] ? sum_mem[req_q.entry] : '0;
      rem_q  <= '0;
      div_i_q <= 6'(SumW - 1);
    end
    if (state_q == StWrite) begin
      cnt_q   <= cnt_new;
      peak_q  <= peak_new;
      quo_q   <= sum_new;
      rem_q   <= '0;
      div_i_q <= 6'(SumW - 1);
    end
    if (state_q == StDiv) begin
      rem_q   <= (rem_sh >= (SumW+1)'(cnt_q)) ? SumW'(rem_sh - (SumW+1)'(cnt_q))
                                              : rem_sh[SumW-1:0];
      quo_q   <= quo_last;
      div_i_q <= div_i_q - 6'd1;
    end
    if (state_q == StOut && out_free_i) begin
      res_q.deviation   <= dev_q;
      res_q.layer_index <= (req_q.op == OpRead) ? req_q.sel :
                           (req_q.in_win ? SelW'(req_q.entry) : '0);
      res_q.in_window   <= (req_q.op == OpRead) ? sel_ok : req_q.in_win;
      if (((req_q.op == OpRead) && sel_ok) ||
          ((req_q.op == OpPoint) && req_q.in_win)) begin
        res_q.point_count <= cnt_q;
        res_q.layer_rmse  <= (cnt_q == '0) ? '0 :
                             (sq_root > 26'(PeakMax)) ? PeakMax : sq_root[PeakW-1:0];
        res_q.layer_max   <= peak_q;
      end else begin
        res_q.point_count <= '0;
        res_q.layer_rmse  <= '0;
        res_q.layer_max   <= '0;
      end
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_start |-> !sq_busy) else $error("root unit restarted while busy");
  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWrite |-> $past(state_q) == StRead) else $error("write without read");
  a_deq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> state_q != StIdle) else $error("request lost");
`endif

endmodule

### hdl/cylinder_residual_layer_stats.sv
// Cylinder residual layer statistics.
// Input channel: valid_i / stall_o with opcode_i, pos_*_i, layer_select_i.
// Opcode point: reports the radial deviation from the configured cylinder and
// updates the one-metre layer that the point falls into. Opcode read: reports
// count, RMSE and maximum of the layer in layer_select_i.
// Output channel: valid_o / stall_i with one result per request.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Timing: one request at a time. The front forms differences, then squares;
// for a point inside the table the back runs a 26-step root, a 50-step long
// division for the mean and a second 26-step root. A read of a valid layer
// runs only the division and the second root; a point outside the table runs
// only the first root. The next request is accepted at the earliest in the
// cycle after the result is taken.
// Reset clears all layer statistics at once (per-entry valid bits) and loads
// the register reset values. A stall on the output holds the result in the
// output register; the block takes no new request until it is delivered.
module cylinder_residual_layer_stats (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic                                opcode_i,
  input  logic signed [crls_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [crls_pkg::CoordW-1:0]  pos_y_i,
  input  logic signed [crls_pkg::CoordW-1:0]  pos_z_i,
  input  logic [crls_pkg::SelW-1:0]           layer_select_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [15:0]                  deviation_o,
  output logic [crls_pkg::SelW-1:0]           layer_index_o,
  output logic                                in_window_o,
  output logic [crls_pkg::CountW-1:0]         point_count_o,
  output logic [crls_pkg::PeakW-1:0]          layer_rmse_o,
  output logic [crls_pkg::PeakW-1:0]          layer_max_o,
  input  logic                                cfg_we_i,
  input  logic [crls_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [crls_pkg::CfgDataW-1:0]       cfg_data_i
);
  import crls_pkg::*;

  logic signed [CoordW-1:0] axis_x_q, axis_y_q;
  logic [18:0]              radius_q;
  logic signed [9:0]        lowest_q;
  logic  take, full, avail, deq, res_vld, busy_q;
  req_t  req;
  res_t  res;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q <= '0;
      axis_y_q <= '0;
      radius_q <= 19'd17408;
      lowest_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegAxisX:  axis_x_q <= cfg_data_i;
        RegAxisY:  axis_y_q <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i[18:0];
        RegLowest: lowest_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // one request in flight from acceptance to delivery
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b0;
    else if (take) busy_q <= 1'b1;
    else if (res_vld && !stall_i) busy_q <= 1'b0;
  end

  assign stall_o = busy_q || full;
  assign take    = valid_i && !stall_o;

  crls_front u_front (
    .clk_i, .rst_ni, .take_i(take),
    .opcode_i, .pos_x_i, .pos_y_i, .pos_z_i, .layer_select_i,
    .axis_x_i(axis_x_q), .axis_y_i(axis_y_q), .lowest_i(lowest_q),
    .deq_i(deq), .full_o(full), .avail_o(avail), .req_o(req)
  );

  crls_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .req_i(req), .radius_i(radius_q),
    .out_free_i(!res_vld || !stall_i), .deq_o(deq),
    .res_vld_o(res_vld), .res_o(res)
  );

  assign valid_o       = res_vld;
  assign deviation_o   = res.deviation;
  assign layer_index_o = res.layer_index;
  assign in_window_o   = res.in_window;
  assign point_count_o = res.point_count;
  assign layer_rmse_o  = res.layer_rmse;
  assign layer_max_o   = res.layer_max;

`ifndef SYNTHESIS
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_q) else $error("result without request");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !take) else $error("request taken while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(deviation_o)) else $error("result dropped");
`endif

endmodule

### bench/crls_checker.sv
`timescale 1ns / 100ps

module crls_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic                               stall_o,
  input  logic                               opcode_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [crls_pkg::CoordW-1:0] pos_z_i,
  input  logic [crls_pkg::SelW-1:0]          layer_select_i,
  input  logic                               valid_o,
  input  logic                               stall_i,
  input  logic signed [15:0]                 deviation_o,
  input  logic [crls_pkg::SelW-1:0]          layer_index_o,
  input  logic                               in_window_o,
  input  logic [crls_pkg::CountW-1:0]        point_count_o,
  input  logic [crls_pkg::PeakW-1:0]         layer_rmse_o,
  input  logic [crls_pkg::PeakW-1:0]         layer_max_o,
  input  logic                               cfg_we_i,
  input  logic [crls_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [crls_pkg::CfgDataW-1:0]      cfg_data_i,
  output int                                 fail_count,
  output int                                 pending
);
  import crls_pkg::*;

  // model copy of the registers
  logic signed [19:0] axis_x_q;
  logic signed [19:0] axis_y_q;
  logic [18:0]        radius_q;
  logic signed [9:0]  lowest_q;

  // model copy of the layer tables
  logic [SumW-1:0]   sum_sq_tbl [LayerCount];
  logic [CountW-1:0] count_tbl  [LayerCount];
  logic [PeakW-1:0]  peak_tbl   [LayerCount];

  res_t expected_results[$];

  assign pending = expected_results.size();

  // integer square root rounded to nearest
  function automatic longint unsigned root_nearest(longint unsigned s);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem = s;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root++;
    return root;
  endfunction

  // fill the statistics fields of one layer entry
  function automatic res_t entry_fields(res_t r, int unsigned e);
    longint unsigned rms;
    rms = 0;
    if (count_tbl[e] != 0) rms = root_nearest(64'(sum_sq_tbl[e]) / 64'(count_tbl[e]));
    if (rms > 32767) rms = 32767;
    r.point_count = count_tbl[e];
    r.layer_rmse = rms[PeakW-1:0];
    r.layer_max = peak_tbl[e];
    return r;
  endfunction

  // work out the result of one request and update the tables
  function automatic res_t predict_layer_result(logic op, logic signed [19:0] px,
      logic signed [19:0] py, logic signed [19:0] pz, logic [SelW-1:0] sel);
    res_t r;
    longint dx;
    longint dy;
    longint dev;
    longint unsigned mag;
    int layer;
    int entry;
    r = '0;
    if (op_e'(op) == OpRead) begin
      r.layer_index = sel;
      if (sel < LayerCount) begin
        r.in_window = 1'b1;
        r = entry_fields(r, sel);
      end
      return r;
    end
    dx = longint'(px) - longint'(axis_x_q);
    dy = longint'(py) - longint'(axis_y_q);
    dev = longint'(root_nearest(64'(dx * dx) + 64'(dy * dy))) - longint'(radius_q);
    if (dev > 32767) dev = 32767;
    if (dev < -32768) dev = -32768;
    r.deviation = dev[15:0];
    mag = (dev < 0) ? 64'(-dev) : 64'(dev);
    if (mag > 32767) mag = 32767;
    layer = int'(pz) >>> 10;
    entry = layer - int'(lowest_q);
    if (entry >= 0 && entry < int'(LayerCount)) begin
      if (count_tbl[entry] != CountMax) begin
        count_tbl[entry] = count_tbl[entry] + 1'b1;
        sum_sq_tbl[entry] = sum_sq_tbl[entry] + SumW'(mag * mag);
      end
      if (mag > 64'(peak_tbl[entry])) peak_tbl[entry] = mag[PeakW-1:0];
      r.layer_index = entry[SelW-1:0];
      r.in_window = 1'b1;
      r = entry_fields(r, entry);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  // track registers, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      axis_x_q <= '0;
      axis_y_q <= '0;
      radius_q <= 19'd17408;
      lowest_q <= '0;
      for (int i = 0; i < LayerCount; i++) begin
        sum_sq_tbl[i] = '0;
        count_tbl[i] = '0;
        peak_tbl[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegAxisX: axis_x_q <= cfg_data_i;
          RegAxisY: axis_y_q <= cfg_data_i;
          RegRadius: radius_q <= cfg_data_i[18:0];
          RegLowest: lowest_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (valid_i && !stall_o) begin
        expected_results.insert(expected_results.size(),
            predict_layer_result(opcode_i, pos_x_i, pos_y_i, pos_z_i, layer_select_i));
      end
      if (valid_o && !stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (deviation_o !== want.deviation)
            report_mismatch("deviation", deviation_o, want.deviation);
          if (layer_index_o !== want.layer_index)
            report_mismatch("layer_index", layer_index_o, want.layer_index);
          if (in_window_o !== want.in_window)
            report_mismatch("in_window", in_window_o, want.in_window);
          if (point_count_o !== want.point_count)
            report_mismatch("point_count", point_count_o, want.point_count);
          if (layer_rmse_o !== want.layer_rmse)
            report_mismatch("layer_rmse", layer_rmse_o, want.layer_rmse);
          if (layer_max_o !== want.layer_max)
            report_mismatch("layer_max", layer_max_o, want.layer_max);
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

### bench/cylinder_residual_layer_stats_tb.sv
`timescale 1ns / 100ps

module cylinder_residual_layer_stats_tb;
  import crls_pkg::*;

  localparam int DrainCycles = 160;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     valid_i;
  logic                     stall_o;
  logic                     opcode_i;
  logic signed [CoordW-1:0] pos_x_i;
  logic signed [CoordW-1:0] pos_y_i;
  logic signed [CoordW-1:0] pos_z_i;
  logic [SelW-1:0]          layer_select_i;
  logic                     valid_o;
  logic                     stall_i;
  logic signed [15:0]       deviation_o;
  logic [SelW-1:0]          layer_index_o;
  logic                     in_window_o;
  logic [CountW-1:0]        point_count_o;
  logic [PeakW-1:0]         layer_rmse_o;
  logic [PeakW-1:0]         layer_max_o;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_data_i;

  int fail_count;
  int pending;
  bit quiet;
  int n_points;
  int n_reads;
  int n_settings;

  // current settings, used to aim points at the cylinder
  int cur_ax;
  int cur_ay;
  int cur_radius;
  int cur_lowest;

  cylinder_residual_layer_stats i_dut (.*);

  crls_checker i_checker (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // receiver: random stall, one long hold-off, quiet stretch
  initial begin
    int cyc;
    cyc = 0;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 30000 && cyc < 30600) stall_i <= 1'b1;
      else if (quiet) stall_i <= 1'b0;
      else stall_i <= ($urandom_range(99) < 25);
    end
  end

  function automatic int clamp20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return int'(v);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(op_e op, int x, int y, int z, int sel);
    if (!quiet && $urandom_range(99) < 25) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    opcode_i <= op;
    pos_x_i <= x[19:0];
    pos_y_i <= y[19:0];
    pos_z_i <= z[19:0];
    layer_select_i <= sel[5:0];
    do @(posedge clk_i); while (stall_o);
    if (op == OpRead) n_reads++;
    else n_points++;
  endtask

  // drop valid and wait for the block to go idle
  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // drive one register write; the caller drops the enable
  task automatic write_reg(reg_idx_e idx, int value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[19:0];
    @(posedge clk_i);
  endtask

  task automatic apply_settings(int ax, int ay, int radius, int lowest);
    drain();
    write_reg(RegAxisX, ax);
    write_reg(RegAxisY, ay);
    write_reg(RegRadius, radius);
    write_reg(RegLowest, lowest);
    cfg_we_i <= 1'b0;
    cur_ax = ax;
    cur_ay = ay;
    cur_radius = radius;
    cur_lowest = lowest;
    n_settings++;
  endtask

  // mostly points near the cylinder inside the table, some reads and noise
  task automatic send_random_request();
    int pick;
    int dx;
    int dy;
    int z;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_request(OpRead, $urandom, $urandom, $urandom, $urandom_range(63));
    end else if (pick < 85) begin
      dx = cur_radius + $signed($urandom_range(4000)) - 2000;
      dy = $signed($urandom_range(2047)) - 1024;
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) begin
        z = dx;
        dx = dy;
        dy = z;
      end
      z = clamp20(longint'(cur_lowest + $signed($urandom_range(63))) * 1024
          + $urandom_range(1023));
      send_request(OpPoint, clamp20(longint'(cur_ax) + dx),
          clamp20(longint'(cur_ay) + dy), z, $urandom_range(63));
    end else begin
      send_request(OpPoint, $signed($urandom) >>> 12, $signed($urandom) >>> 12,
          $signed($urandom) >>> 12, $urandom_range(63));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    opcode_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    layer_select_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    quiet = 1'b0;
    n_points = 0;
    n_reads = 0;
    n_settings = 1;
    cur_ax = 0;
    cur_ay = 0;
    cur_radius = 17408;
    cur_lowest = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: on the axis, on the surface, far out, layer edges
    send_request(OpRead, 0, 0, 0, 0);
    send_request(OpPoint, 0, 0, 10, 0);
    send_request(OpPoint, 17408, 0, 1023, 0);
    send_request(OpPoint, 524287, 524287, 2048, 0);
    send_request(OpPoint, -524288, -524288, 63 * 1024, 0);
    send_request(OpPoint, 0, 17500, 64 * 1024, 0);
    send_request(OpPoint, 0, -17000, -1, 0);
    send_request(OpPoint, 100, 100, -524288, 0);
    send_request(OpPoint, 100, 100, 524287, 0);
    send_request(OpRead, 0, 0, 0, 63);
    send_request(OpRead, 0, 0, 0, 2);

    // axis at opposite corners, largest radius, lowest table
    apply_settings(-524288, 524287, 524287, -512);
    send_request(OpPoint, 524287, -524288, -524288, 0);
    send_request(OpPoint, -524288, 524287, -524288 + 1024, 0);
    send_request(OpPoint, 0, 0, -524288 + 63 * 1024 + 1023, 0);
    send_request(OpRead, 0, 0, 0, 1);
    send_request(OpRead, 0, 0, 0, 0);

    // zero radius, highest table: only the top metre is reachable
    apply_settings(524287, -524288, 0, 511);
    send_request(OpPoint, 524287, -524288, 524287, 0);
    send_request(OpPoint, 524287, -524287, 524287, 0);
    send_request(OpPoint, 0, 0, 524287, 0);
    send_request(OpPoint, 524287, -524288, 0, 0);
    send_request(OpRead, 0, 0, 0, 0);

    // random phases, each with its own settings
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) apply_settings(0, 0, 17408, -30);
      else apply_settings($signed($urandom_range(400000)) - 200000,
          $signed($urandom_range(400000)) - 200000, $urandom_range(500, 40000),
          $signed($urandom_range(1023)) - 512);
      quiet = (phase == 3);
      for (int i = 0; i < 225; i++) send_random_request();
      // sender pauses until the block has caught up
      if (phase == 5) begin
        quiet = 1'b0;
        drain();
      end
    end
    quiet = 1'b0;

    // final sweep over every table entry
    for (int s = 0; s < 64; s++) send_request(OpRead, 0, 0, 0, s);
    drain();

    $display("covered %0d point requests and %0d layer reads under %0d register settings",
        n_points, n_reads, n_settings);
    $display("including output hold-off, input back-pressure and window edges");
    if (fail_count == 0) begin
      $display("cylinder_residual_layer_stats_tb: PASS");
    end else begin
      $display("cylinder_residual_layer_stats_tb: FAIL");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #20ms;
    $display("cylinder_residual_layer_stats_tb: FAIL");
    $finish;
  end

endmodule
